// ===== sv/tem_pkg.sv =====
// Shared types and constants of the text extent measurement block.
package tem_pkg;

    localparam int GLYPH_ENTRIES_DEF = 128;
    localparam int CFG_DATA_W = 24;
    localparam int FIX_W = 32;
    localparam int PX_W = 16;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx REG_FIRST_CHAR = 3'd0;
    localparam t_cfg_idx REG_GLYPH_COUNT = 3'd1;
    localparam t_cfg_idx REG_ALLOW_LOWERCASE = 3'd2;
    localparam t_cfg_idx REG_SCALE = 3'd3;
    localparam t_cfg_idx REG_LINE_HEIGHT = 3'd4;

    localparam logic [6:0] FIRST_CHAR_RST = 7'd32;
    localparam logic [7:0] GLYPH_COUNT_RST = 8'd0;
    localparam logic [23:0] SCALE_RST = 24'd65536;
    localparam logic [7:0] LINE_HEIGHT_RST = 8'd0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CHAR = 1'b1;

    localparam logic [6:0] CHAR_END = 7'h00;
    localparam logic [6:0] CHAR_NEWLINE = 7'h0a;
    localparam logic [6:0] CHAR_LC_A = 7'h61;
    localparam logic [6:0] CHAR_LC_Z = 7'h7a;
    localparam logic [6:0] CASE_OFFSET = 7'd32;

    typedef enum logic [1:0] {
        KIND_GLYPH,
        KIND_NEWLINE,
        KIND_END
    } t_kind;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [FIX_W-1:0] adv;
    } t_step;

endpackage

// ===== sv/tem_in_if.sv =====
// Request channel carrying glyph loads and string characters.
interface tem_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [6:0] glyph_index;
    logic [7:0] glyph_width;
    logic       glyph_present;
    logic [7:0] char_code;

    modport source (
        output valid, operation, glyph_index, glyph_width, glyph_present, char_code,
        input  ready
    );
    modport sink (
        input  valid, operation, glyph_index, glyph_width, glyph_present, char_code,
        output ready
    );
endinterface

// ===== sv/tem_out_if.sv =====
// Result channel carrying the measured width and height of a string.
interface tem_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] width_px;
    logic [15:0] height_px;

    modport source (
        output valid, width_px, height_px,
        input  ready
    );
    modport sink (
        input  valid, width_px, height_px,
        output ready
    );
endinterface

// ===== sv/tem_accum.sv =====
// Cursor, widest line and total height accumulators with saturation.
module tem_accum
    import tem_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  t_step           i_step,
    input  logic            i_line_reload,
    input  logic [7:0]      i_line_height,
    output logic [PX_W-1:0] o_width_px,
    output logic [PX_W-1:0] o_height_px
);

    logic [FIX_W-1:0] r_cursor, n_cursor;
    logic [FIX_W-1:0] r_widest, n_widest;
    logic [FIX_W-1:0] r_total, n_total;
    logic [FIX_W:0]   w_cur_sum;
    logic [FIX_W:0]   w_tot_sum;
    logic [FIX_W-1:0] w_cur_sat;
    logic [FIX_W-1:0] w_tot_sat;

    assign w_cur_sum = {1'b0, r_cursor} + {1'b0, i_step.adv};
    assign w_tot_sum = {1'b0, r_total} + {1'b0, i_step.adv};
    assign w_cur_sat = w_cur_sum[FIX_W] ? {FIX_W{1'b1}} : w_cur_sum[FIX_W-1:0];
    assign w_tot_sat = w_tot_sum[FIX_W] ? {FIX_W{1'b1}} : w_tot_sum[FIX_W-1:0];

    always_comb begin
        n_cursor = r_cursor;
        n_widest = r_widest;
        n_total  = r_total;
        if (i_line_reload) begin
            n_total = {8'd0, i_line_height, 16'd0};
        end else if (i_en && i_step.valid) begin
            case (i_step.kind)
                KIND_END: begin
                    n_cursor = '0;
                    n_widest = '0;
                    n_total  = {8'd0, i_line_height, 16'd0};
                end
                KIND_NEWLINE: begin
                    n_cursor = '0;
                    n_total  = w_tot_sat;
                end
                KIND_GLYPH: begin
                    n_cursor = w_cur_sat;
                    if (w_cur_sat > r_widest) begin
                        n_widest = w_cur_sat;
                    end
                end
                default: begin
                    n_cursor = r_cursor;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_widest <= '0;
            r_total  <= {8'd0, LINE_HEIGHT_RST, 16'd0};
        end else begin
            r_cursor <= n_cursor;
            r_widest <= n_widest;
            r_total  <= n_total;
        end
    end

    assign o_width_px  = r_widest[FIX_W-1:FIX_W-PX_W];
    assign o_height_px = r_total[FIX_W-1:FIX_W-PX_W];

endmodule

// ===== sv/text_extent_measure.sv =====
// Top level of the text extent measurement block.
//
// Requests arrive on i_in. A load request writes one glyph table entry (width
// and presence) and yields no result. A character request advances the cursor
// by the scaled glyph width, a newline starts a new line, and a zero code ends
// the string and yields one result on o_out with the widest line and the total
// height in whole pixels, both saturated at 65535.
// Configuration registers are written through i_cfg_wr_en, i_cfg_index and
// i_cfg_data; the user must write them only while no string is in flight,
// which the block does not enforce. One request is taken every cycle unless
// the input stalls. A string end passes the glyph table read register and the
// width times scale multiply into the step register, then the result register,
// loaded as the accumulators clear. The input stalls only when a string end
// reaches the last stage while the previous result is still waiting to be
// taken. Reset clears the configuration to its defaults, marks every glyph
// absent and empties the pipeline; the glyph widths keep no reset value.
module text_extent_measure
    import tem_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tem_in_if.sink                i_in,
    tem_out_if.source             o_out,
    input  logic                  i_cfg_wr_en,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam logic [7:0] ENTRIES_8 = 8'(GLYPH_ENTRIES);

    logic [6:0]  r_first_char;
    logic [7:0]  r_glyph_count;
    logic        r_allow_lc;
    logic [23:0] r_scale;
    logic [7:0]  r_line_height;

    logic [7:0]               r_width_mem [GLYPH_ENTRIES];
    logic [GLYPH_ENTRIES-1:0] r_present;
    logic [7:0]               r_w0;
    logic [7:0]               r_rd_width;

    logic        r1_valid;
    t_kind       r1_kind;
    logic        r1_hit;
    t_step       r2_step;

    logic        r_out_valid;
    logic [15:0] r_out_width;
    logic [15:0] r_out_height;

    logic             w_advance;
    logic             w_accept;
    logic             w_load_wr;
    logic [IDX_W-1:0] w_wr_idx;
    logic [6:0]       w_code;
    logic [6:0]       w_fold;
    logic [6:0]       w_diff;
    logic [7:0]       w_count;
    logic             w_in_range;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_hit;
    t_kind            w_kind;
    logic [7:0]       w_operand;
    logic [FIX_W-1:0] w_prod;
    logic [FIX_W-1:0] w_adv;
    logic             w_end_fire;
    logic             w_line_reload;
    logic [PX_W-1:0]  w_width_px;
    logic [PX_W-1:0]  w_height_px;

    assign w_advance = !(r2_step.valid && (r2_step.kind == KIND_END) &&
                         r_out_valid && !o_out.ready);
    assign i_in.ready = w_advance;
    assign w_accept = i_in.valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_char  <= FIRST_CHAR_RST;
            r_glyph_count <= GLYPH_COUNT_RST;
            r_allow_lc    <= 1'b0;
            r_scale       <= SCALE_RST;
            r_line_height <= LINE_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_FIRST_CHAR:      r_first_char  <= i_cfg_data[6:0];
                REG_GLYPH_COUNT:     r_glyph_count <= i_cfg_data[7:0];
                REG_ALLOW_LOWERCASE: r_allow_lc    <= i_cfg_data[0];
                REG_SCALE:           r_scale       <= i_cfg_data[23:0];
                REG_LINE_HEIGHT:     r_line_height <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign w_line_reload = i_cfg_wr_en && (i_cfg_index == REG_LINE_HEIGHT);

    // Character decode: case folding, table offset and range check.
    always_comb begin
        w_code = i_in.char_code[6:0];
        w_fold = w_code;
        if (!r_allow_lc && (w_code inside {[CHAR_LC_A:CHAR_LC_Z]})) begin
            w_fold = w_code - CASE_OFFSET;
        end
        w_diff = w_fold - r_first_char;
        w_count = (r_glyph_count > ENTRIES_8) ? ENTRIES_8 : r_glyph_count;
        w_in_range = (w_fold >= r_first_char) && ({1'b0, w_diff} < w_count);
        w_rd_idx = IDX_W'(w_diff);
        w_hit = w_in_range && r_present[w_rd_idx];
        if (w_code == CHAR_END) begin
            w_kind = KIND_END;
        end else if (w_code == CHAR_NEWLINE) begin
            w_kind = KIND_NEWLINE;
        end else begin
            w_kind = KIND_GLYPH;
        end
    end

    assign w_load_wr = w_accept && (i_in.operation == OP_LOAD) &&
                       ({1'b0, i_in.glyph_index} < ENTRIES_8);
    assign w_wr_idx = IDX_W'(i_in.glyph_index);

    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            r_width_mem[w_wr_idx] <= i_in.glyph_width;
        end
        if (w_advance) begin
            r_rd_width <= r_width_mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_wr && (w_wr_idx == '0)) begin
            r_w0 <= i_in.glyph_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (w_load_wr) begin
            r_present[w_wr_idx] <= i_in.glyph_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_advance) begin
            r1_valid <= w_accept && (i_in.operation == OP_CHAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r1_kind <= w_kind;
            r1_hit  <= w_hit;
        end
    end

    // Advance in 16.16: the glyph width, half of glyph zero, or a line height.
    always_comb begin
        if (r1_kind == KIND_NEWLINE) begin
            w_operand = r_line_height;
        end else if (r1_hit) begin
            w_operand = r_rd_width;
        end else begin
            w_operand = r_w0;
        end
        w_prod = FIX_W'(w_operand) * FIX_W'(r_scale);
        if ((r1_kind == KIND_GLYPH) && !r1_hit) begin
            w_adv = w_prod >> 1;
        end else begin
            w_adv = w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_step <= '0;
        end else if (w_advance) begin
            r2_step.valid <= r1_valid;
            r2_step.kind  <= r1_kind;
            r2_step.adv   <= w_adv;
        end
    end

    tem_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_advance),
        .i_step        (r2_step),
        .i_line_reload (w_line_reload),
        .i_line_height (w_line_reload ? i_cfg_data[7:0] : r_line_height),
        .o_width_px    (w_width_px),
        .o_height_px   (w_height_px)
    );

    assign w_end_fire = w_advance && r2_step.valid && (r2_step.kind == KIND_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_end_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end_fire) begin
            r_out_width  <= w_width_px;
            r_out_height <= w_height_px;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.width_px  = r_out_width;
    assign o_out.height_px = r_out_height;

endmodule

// ===== sv/tem_checker.sv =====
// Port-level checks of the text extent measurement block and their binding.
module tem_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_width,
    input logic [15:0] i_out_height
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result request dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_width) && $stable(i_out_height))
        else $error("Result payload changed while stalled.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("Input stalled without a waiting result.");

    a_rise_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_ready))
        else $error("Result appeared while the pipeline was held.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

endmodule

bind text_extent_measure tem_checker u_tem_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_width  (o_out.width_px),
    .i_out_height (o_out.height_px)
);
